// ===== rtl/core/srt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg: shared types and constants of the sorted record table
// command and status codes, field widths and the compare unit's flags
// ----------------------------------------------------------------------------
package srt_pkg;

	// default table size
	localparam int TABLE_DEPTH_DEF = 64;

	// field widths
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 16;
	localparam int TAG_W    = 32;
	localparam int STATUS_W = 3;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 2'd0,
		CMD_DUMP_ASC  = 2'd1,
		CMD_DUMP_DESC = 2'd2,
		CMD_LOOKUP    = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_RECORD   = 3'd0,
		ST_INSERTED = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// flags from the shared key compare unit
	typedef struct packed {
		logic le;      // stored key <= search key
		logic eq;      // stored key == search key
		logic eq_min;  // search key == smallest stored key
	} cmp_flags_t;

endpackage
`default_nettype wire

// ===== rtl/core/srt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srt_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, no reset on contents
// ----------------------------------------------------------------------------
module srt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/srt_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srt_cmp: shared key compare unit
// compares the key read from the table against the search key and the
// search key against the smallest stored key
// ----------------------------------------------------------------------------
module srt_cmp (
	input  wire logic [srt_pkg::KEY_W-1:0] rd_key,
	input  wire logic [srt_pkg::KEY_W-1:0] srch_key,
	input  wire logic [srt_pkg::KEY_W-1:0] min_key,
	output srt_pkg::cmp_flags_t            flags
);
	import srt_pkg::*;

	// one magnitude compare and two equality checks
	always_comb begin
		flags.le     = (rd_key <= srch_key);
		flags.eq     = (rd_key == srch_key);
		flags.eq_min = (srch_key == min_key);
	end

endmodule
`default_nettype wire

// ===== rtl/core/sorted_record_table_core.sv =====
`default_nettype none
// insert: answered from idle when full or empty, else one shift step per
//   record moved, through the single key/tag ram port pair
// dump: answered from idle when empty, else one record per cycle
// lookup: answered from idle when empty, else one compare
//   per cycle; busy stays high until the final result, results cannot stall
// reset clears the entry count and sequencer; ram contents are not cleared
// ----------------------------------------------------------------------------
// sorted_record_table_core: key-ordered record table with insert, dump and
// lookup, run by a small sequencer over one shared compare unit and rams
// ----------------------------------------------------------------------------
module sorted_record_table_core #(
	parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [srt_pkg::CMD_W-1:0]    command,
	input  wire logic [srt_pkg::KEY_W-1:0]    key,
	input  wire logic [srt_pkg::TAG_W-1:0]    payload_tag,
	output logic                              valid,
	output logic [srt_pkg::STATUS_W-1:0]      status,
	output logic [srt_pkg::KEY_W-1:0]         out_key,
	output logic [srt_pkg::TAG_W-1:0]         out_tag,
	output logic                              last
);
	import srt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE      = 5'b00001,
		S_INS       = 5'b00010,
		S_INS_FRONT = 5'b00100,
		S_DUMP      = 5'b01000,
		S_LOOK      = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d, cnt_m1;
	logic [AW-1:0]      idx_q, idx_d, idx_nxt, idx_prv;
	logic [CW-1:0]      rem_q, rem_d;
	logic               desc_q, desc_d;
	logic [KEY_W-1:0]   k_q, k_d, min_key_q;
	logic [TAG_W-1:0]   tag_q, tag_d;

	logic               valid_q, valid_d, last_q, last_d;
	status_t            status_q, status_d;
	logic [KEY_W-1:0]   okey_q, okey_d;
	logic [TAG_W-1:0]   otag_q, otag_d;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [KEY_W-1:0]   wkey, rd_key, srch_key;
	logic [TAG_W-1:0]   wtag, rd_tag;
	cmp_flags_t         flags;

	// record storage
	srt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wkey),
		.raddr (raddr),
		.rdata (rd_key)
	);

	srt_ram #(.WIDTH(TAG_W), .DEPTH(TABLE_DEPTH)) u_tag_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wtag),
		.raddr (raddr),
		.rdata (rd_tag)
	);

	// shared compare unit
	assign srch_key = k_q;

	srt_cmp u_cmp (
		.rd_key   (rd_key),
		.srch_key (srch_key),
		.min_key  (min_key_q),
		.flags    (flags)
	);

	assign cnt_m1  = count_q - CW'(1);
	assign idx_nxt = idx_q + AW'(1);
	assign idx_prv = idx_q - AW'(1);

	// sequencer
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		rem_d    = rem_q;
		desc_d   = desc_q;
		k_d      = k_q;
		tag_d    = tag_q;
		valid_d  = 1'b0;
		status_d = status_q;
		okey_d   = okey_q;
		otag_d   = otag_q;
		last_d   = 1'b1;
		we       = 1'b0;
		waddr    = idx_nxt;
		wkey     = rd_key;
		wtag     = rd_tag;
		raddr    = idx_nxt;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					k_d   = key;
					tag_d = payload_tag;
					case (cmd_t'(command))
						CMD_INSERT: begin
							if (count_q == CW'(TABLE_DEPTH)) begin
								valid_d  = 1'b1;
								status_d = ST_FULL;
								okey_d   = key;
								otag_d   = payload_tag;
							end else if (count_q == '0) begin
								we       = 1'b1;
								waddr    = '0;
								wkey     = key;
								wtag     = payload_tag;
								count_d  = count_q + CW'(1);
								valid_d  = 1'b1;
								status_d = ST_INSERTED;
								okey_d   = key;
								otag_d   = payload_tag;
							end else begin
								idx_d   = cnt_m1[AW-1:0];
								raddr   = cnt_m1[AW-1:0];
								state_d = S_INS;
							end
						end
						CMD_DUMP_ASC, CMD_DUMP_DESC: begin
							if (count_q == '0) begin
								valid_d  = 1'b1;
								status_d = ST_EMPTY;
								okey_d   = '0;
								otag_d   = '0;
							end else begin
								desc_d  = (cmd_t'(command) == CMD_DUMP_DESC);
								idx_d   = desc_d ? cnt_m1[AW-1:0] : '0;
								raddr   = idx_d;
								rem_d   = cnt_m1;
								state_d = S_DUMP;
							end
						end
						CMD_LOOKUP: begin
							if (count_q == '0) begin
								valid_d  = 1'b1;
								status_d = ST_NOTFOUND;
								okey_d   = '0;
								otag_d   = '0;
							end else begin
								idx_d   = '0;
								raddr   = '0;
								state_d = S_LOOK;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end

			// walk down from the top, moving records up until the slot is found
			S_INS: begin
				we = 1'b1;
				if (flags.le && !flags.eq_min) begin
					wkey     = k_q;
					wtag     = tag_q;
					count_d  = count_q + CW'(1);
					valid_d  = 1'b1;
					status_d = ST_INSERTED;
					okey_d   = k_q;
					otag_d   = tag_q;
					state_d  = S_IDLE;
				end else if (idx_q == '0) begin
					state_d = S_INS_FRONT;
				end else begin
					idx_d = idx_prv;
					raddr = idx_prv;
				end
			end

			// new record goes in front of all others
			S_INS_FRONT: begin
				we       = 1'b1;
				waddr    = '0;
				wkey     = k_q;
				wtag     = tag_q;
				count_d  = count_q + CW'(1);
				valid_d  = 1'b1;
				status_d = ST_INSERTED;
				okey_d   = k_q;
				otag_d   = tag_q;
				state_d  = S_IDLE;
			end

			// stream one record per cycle
			S_DUMP: begin
				valid_d  = 1'b1;
				status_d = ST_RECORD;
				okey_d   = rd_key;
				otag_d   = rd_tag;
				last_d   = (rem_q == '0);
				if (rem_q == '0) begin
					state_d = S_IDLE;
				end else begin
					rem_d = rem_q - CW'(1);
					idx_d = desc_q ? idx_prv : idx_nxt;
					raddr = idx_d;
				end
			end

			// linear search from the front
			S_LOOK: begin
				if (flags.eq) begin
					valid_d  = 1'b1;
					status_d = ST_RECORD;
					okey_d   = rd_key;
					otag_d   = rd_tag;
					state_d  = S_IDLE;
				end else if (CW'(idx_q) == cnt_m1) begin
					valid_d  = 1'b1;
					status_d = ST_NOTFOUND;
					okey_d   = '0;
					otag_d   = '0;
					state_d  = S_IDLE;
				end else begin
					idx_d = idx_nxt;
					raddr = idx_nxt;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			valid_q <= valid_d;
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		rem_q    <= rem_d;
		desc_q   <= desc_d;
		k_q      <= k_d;
		tag_q    <= tag_d;
		status_q <= status_d;
		okey_q   <= okey_d;
		otag_q   <= otag_d;
		last_q   <= last_d;
		if (we && (waddr == '0)) begin
			min_key_q <= wkey;
		end
	end

	// outputs
	assign busy    = (state_q != S_IDLE);
	assign valid   = valid_q;
	assign status  = status_q;
	assign out_key = okey_q;
	assign out_tag = otag_q;
	assign last    = last_q;

`ifndef SYNTHESIS
	// table never holds more records than it has room for
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	// an insert result comes with exactly one more record in the table
	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (status_q == ST_INSERTED)) |-> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table by one");

	// a full result is only given when the table is full
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (status_q == ST_FULL)) |-> (count_q == CW'(TABLE_DEPTH)))
		else $error("full status with room left");

	// a dump produces a record on every cycle it runs
	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> (valid_q && (status_q == ST_RECORD)))
		else $error("dump cycle without a record");

	// the sequencer only leaves idle on an accepted item
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without an accepted item");
`endif

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_record_table_core
// directed table rows, then random inserts, lookups and dumps under several
// idle patterns; responses checked against typed-in values or a shadow table
// ----------------------------------------------------------------------------
module testbench;
	import srt_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int N_DIRECTED = 18;

	// one response as seen on the result ports
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    rkey;
		logic [TAG_W-1:0]    rtag;
		logic                rlast;
	} response_t;

	// one directed item, with an optional typed-in response
	typedef struct packed {
		cmd_t              cmd;
		logic [KEY_W-1:0]  ikey;
		logic [TAG_W-1:0]  itag;
		logic              typed;
		response_t         resp;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  command;
	logic [KEY_W-1:0]  key;
	logic [TAG_W-1:0]  payload_tag;
	logic              valid;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]  out_key;
	logic [TAG_W-1:0]  out_tag;
	logic              last;

	// shadow table and response bookkeeping
	logic [KEY_W-1:0] tbl_key [DEPTH];
	logic [TAG_W-1:0] tbl_tag [DEPTH];
	int               tbl_count = 0;
	response_t        step_responses [$];
	response_t        pending_responses [$];
	int               errors = 0;
	int               n_checked = 0;
	int               n_items = 0;
	int               n_inserted = 0;
	int               n_refused = 0;
	int               n_dumps = 0;
	int               n_hits = 0;
	int               n_misses = 0;

	sorted_record_table_core #(
		.TABLE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.key(key),
		.payload_tag(payload_tag),
		.valid(valid),
		.status(status),
		.out_key(out_key),
		.out_tag(out_tag),
		.last(last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// shadow table: apply one command, leave its responses in step_responses
	function automatic void shadow_table_command(cmd_t c, logic [KEY_W-1:0] k,
			logic [TAG_W-1:0] t);
		int pos;
		int i;
		int idx;
		step_responses.delete();
		case (c)
			CMD_INSERT: begin
				if (tbl_count >= DEPTH) begin
					step_responses.push_back('{ST_FULL, k, t, 1'b1});
					n_refused++;
				end else begin
					// equal to the smallest key goes in front, else after all keys <= k
					pos = 0;
					if (tbl_count != 0 && k > tbl_key[0]) begin
						while (pos < tbl_count && tbl_key[pos] <= k)
							pos++;
					end
					for (i = tbl_count; i > pos; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_tag[i] = tbl_tag[i-1];
					end
					tbl_key[pos] = k;
					tbl_tag[pos] = t;
					tbl_count++;
					step_responses.push_back('{ST_INSERTED, k, t, 1'b1});
					n_inserted++;
				end
			end
			CMD_DUMP_ASC, CMD_DUMP_DESC: begin
				n_dumps++;
				if (tbl_count == 0) begin
					step_responses.push_back('{ST_EMPTY, '0, '0, 1'b1});
				end else begin
					for (i = 0; i < tbl_count; i++) begin
						idx = (c == CMD_DUMP_DESC) ? tbl_count - 1 - i : i;
						step_responses.push_back('{ST_RECORD, tbl_key[idx], tbl_tag[idx],
							(i == tbl_count - 1)});
					end
				end
			end
			default: begin
				// first match in ascending order
				pos = -1;
				for (i = 0; i < tbl_count; i++) begin
					if (pos < 0 && tbl_key[i] == k)
						pos = i;
				end
				if (pos >= 0) begin
					step_responses.push_back('{ST_RECORD, tbl_key[pos], tbl_tag[pos], 1'b1});
					n_hits++;
				end else begin
					step_responses.push_back('{ST_NOTFOUND, '0, '0, 1'b1});
					n_misses++;
				end
			end
		endcase
	endfunction

	// drive one item at a falling edge and hold it until accepted
	task automatic issue(input cmd_t c, input logic [KEY_W-1:0] k,
			input logic [TAG_W-1:0] t, input logic typed, input response_t resp);
		command     <= c;
		key         <= k;
		payload_tag <= t;
		start       <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		shadow_table_command(c, k, t);
		if (typed)
			pending_responses.push_back(resp);
		else
			foreach (step_responses[i])
				pending_responses.push_back(step_responses[i]);
		n_items++;
		@(negedge clk);
	endtask

	// wait until every pending response has come back
	task automatic drain;
		start <= 1'b0;
		@(negedge clk);
		while (pending_responses.size() != 0)
			@(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin : check_responses
		response_t head;
		if (arst_n && valid) begin
			if (pending_responses.size() == 0) begin
				$error("unexpected response status=%0d key=%h tag=%h last=%b",
					status, out_key, out_tag, last);
				errors++;
			end else begin
				head = pending_responses.pop_front();
				n_checked++;
				if (status !== head.status) begin
					$error("status: expected %0d, got %0d", head.status, status);
					errors++;
				end
				if (out_key !== head.rkey) begin
					$error("out_key: expected %h, got %h", head.rkey, out_key);
					errors++;
				end
				if (out_tag !== head.rtag) begin
					$error("out_tag: expected %h, got %h", head.rtag, out_tag);
					errors++;
				end
				if (last !== head.rlast) begin
					$error("last: expected %b, got %b", head.rlast, last);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin : stimulus
		stim_row_t   directed_rows [N_DIRECTED];
		int          idle_pct [4];
		int          phase;
		int          n;
		int          roll;
		cmd_t        c;
		logic [KEY_W-1:0] k;
		logic [TAG_W-1:0] t;

		idle_pct = '{0, 78, 0, 29};
		// directed rows: empty table, extremes, duplicate keys, both dumps
		directed_rows = '{
			'{CMD_DUMP_ASC,  16'h0000, 32'h0000_0000, 1'b1, '{ST_EMPTY, 16'h0, 32'h0, 1'b1}},
			'{CMD_DUMP_DESC, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 16'h0, 32'h0, 1'b1}},
			'{CMD_LOOKUP,    16'h0000, 32'h0000_0000, 1'b1,
				'{ST_NOTFOUND, 16'h0, 32'h0, 1'b1}},
			'{CMD_LOOKUP,    16'hFFFF, 32'hFFFF_FFFF, 1'b1,
				'{ST_NOTFOUND, 16'h0, 32'h0, 1'b1}},
			'{CMD_INSERT,    16'hFFFF, 32'hFFFF_FFFF, 1'b1,
				'{ST_INSERTED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1}},
			'{CMD_INSERT,    16'h0000, 32'h0000_0000, 1'b1,
				'{ST_INSERTED, 16'h0000, 32'h0000_0000, 1'b1}},
			'{CMD_INSERT,    16'h0000, 32'h0000_0001, 1'b1,
				'{ST_INSERTED, 16'h0000, 32'h0000_0001, 1'b1}},
			'{CMD_INSERT,    16'h8000, 32'hA5A5_A5A5, 1'b1,
				'{ST_INSERTED, 16'h8000, 32'hA5A5_A5A5, 1'b1}},
			'{CMD_INSERT,    16'h8000, 32'h5A5A_5A5A, 1'b1,
				'{ST_INSERTED, 16'h8000, 32'h5A5A_5A5A, 1'b1}},
			'{CMD_INSERT,    16'hFFFF, 32'h0000_0002, 1'b1,
				'{ST_INSERTED, 16'hFFFF, 32'h0000_0002, 1'b1}},
			'{CMD_INSERT,    16'h7FFF, 32'h1234_5678, 1'b1,
				'{ST_INSERTED, 16'h7FFF, 32'h1234_5678, 1'b1}},
			'{CMD_DUMP_ASC,  16'h5555, 32'hAAAA_AAAA, 1'b0, '0},
			'{CMD_DUMP_DESC, 16'hAAAA, 32'h5555_5555, 1'b0, '0},
			'{CMD_LOOKUP,    16'h0000, 32'h0000_0000, 1'b0, '0},
			'{CMD_LOOKUP,    16'h8000, 32'h0000_0000, 1'b0, '0},
			'{CMD_LOOKUP,    16'hFFFF, 32'h0000_0000, 1'b0, '0},
			'{CMD_LOOKUP,    16'h1234, 32'h0000_0000, 1'b1,
				'{ST_NOTFOUND, 16'h0, 32'h0, 1'b1}},
			'{CMD_LOOKUP,    16'h7FFF, 32'h0000_0000, 1'b0, '0}
		};

		// known values from time zero with reset asserted, then reset released
		arst_n      = 1'b0;
		start       = 1'b0;
		command     = CMD_INSERT;
		key         = '0;
		payload_tag = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, back to back
		foreach (directed_rows[r])
			issue(directed_rows[r].cmd, directed_rows[r].ikey, directed_rows[r].itag,
				directed_rows[r].typed, directed_rows[r].resp);
		drain();

		// random phases, each with its own sender idle rate
		for (phase = 0; phase < 4; phase++) begin
			for (n = 0; n < 58; n++) begin
				if ($urandom_range(0, 99) < idle_pct[phase]) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
				end
				t = $urandom;
				roll = $urandom_range(0, 99);
				// keys drawn mostly from a small pool make duplicates and extremes likely
				case ($urandom_range(0, 4))
					0: k = 16'h0000;
					1: k = 16'hFFFF;
					2: k = 16'($urandom_range(0, 15));
					default: k = 16'($urandom);
				endcase
				if (roll < 45) begin
					c = CMD_INSERT;
				end else if (roll < 80) begin
					c = CMD_LOOKUP;
					if (tbl_count != 0 && $urandom_range(0, 1))
						k = tbl_key[$urandom_range(0, tbl_count - 1)];
				end else if (roll < 90) begin
					c = CMD_DUMP_ASC;
				end else begin
					c = CMD_DUMP_DESC;
				end
				issue(c, k, t, 1'b0, '0);
				// occasional full pause mid-phase
				if ($urandom_range(0, 39) == 0)
					drain();
			end
			drain();

			// after the second phase, fill the table and hit the full case
			if (phase == 1) begin
				while (tbl_count < DEPTH)
					issue(CMD_INSERT, 16'($urandom), $urandom, 1'b0, '0);
				issue(CMD_INSERT, 16'h0000, $urandom, 1'b0, '0);
				issue(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0);
				issue(CMD_DUMP_DESC, 16'($urandom), $urandom, 1'b0, '0);
				issue(CMD_DUMP_ASC, 16'($urandom), $urandom, 1'b0, '0);
				drain();
			end
		end

		// let any stray response show up
		start <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (pending_responses.size() != 0) begin
			$error("%0d responses never arrived", pending_responses.size());
			errors++;
		end

		$display("run covered %0d items: %0d inserts, %0d refused as full, %0d dumps",
			n_items, n_inserted, n_refused, n_dumps);
		$display("lookups hit %0d and missed %0d; %0d responses checked, %0d errors",
			n_hits, n_misses, n_checked, errors);
		if (errors == 0)
			$display("PASS sorted_record_table_core");
		else
			$display("FAIL sorted_record_table_core");
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("FAIL sorted_record_table_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/srt_pkg.sv
rtl/core/srt_ram.sv
rtl/core/srt_cmp.sv
rtl/core/sorted_record_table_core.sv
dv/testbench.sv
